// File: src/grid_peak_valley_detector_core_macros.svh
// assertion macros shared by the grid peak and valley detector rtl
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef GRID_PEAK_VALLEY_DETECTOR_CORE_MACROS_SVH
`define GRID_PEAK_VALLEY_DETECTOR_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define GPVD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define GPVD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/gpvd_pkg.sv
// shared types, constants and helpers of the grid peak and valley detector
// no dependencies
package gpvd_pkg;

    localparam int MAX_DIM   = 64;
    localparam int CNT_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = 7;
    localparam int ELEV_W    = 16;
    localparam int CFG_IDX_W = 1;

    localparam int MAX_RES    = 3;
    localparam int PUSH_W     = $clog2(MAX_RES + 1);
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

    typedef enum logic [1:0] {
        KIND_PEAK   = 2'd0,
        KIND_VALLEY = 2'd1,
        KIND_MAX    = 2'd2,
        KIND_MIN    = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [CNT_W-1:0]         row;
        logic [CNT_W-1:0]         col;
        logic signed [ELEV_W-1:0] value;
        logic                     last;
    } t_result;

    // new right-hand column of the 3x3 window
    typedef struct packed {
        logic signed [ELEV_W-1:0] top;
        logic signed [ELEV_W-1:0] mid;
        logic signed [ELEV_W-1:0] bot;
    } t_wnd_col;

    typedef struct packed {
        logic                     above;
        logic                     below;
        logic signed [ELEV_W-1:0] center;
    } t_wnd_status;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v < DIM_W'(3)) begin
            res = DIM_W'(3);
        end else if (v > DIM_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// File: src/gpvd_line_ram.sv
// generic single-port-write, one-read synchronous ram, read-first, registered read data
// no dependencies
module gpvd_line_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/gpvd_window.sv
// 3x3 sample window with strict peak and valley compare on its center
// depends on gpvd_pkg
module gpvd_window (
    input  logic                  i_clk,
    input  logic                  i_shift,
    input  gpvd_pkg::t_wnd_col    i_col,
    output gpvd_pkg::t_wnd_status o_status
);
    import gpvd_pkg::*;

    logic signed [ELEV_W-1:0] r_wnd [9];

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            for (int i = 0; i < 3; i++) begin
                r_wnd[i*3 + 0] <= r_wnd[i*3 + 1];
                r_wnd[i*3 + 1] <= r_wnd[i*3 + 2];
            end
            r_wnd[2] <= i_col.top;
            r_wnd[5] <= i_col.mid;
            r_wnd[8] <= i_col.bot;
        end
    end

    always_comb begin
        o_status.above  = 1'b1;
        o_status.below  = 1'b1;
        o_status.center = r_wnd[4];
        for (int i = 0; i < 9; i++) begin
            if (i != 4) begin
                if (!($signed(r_wnd[4]) > $signed(r_wnd[i]))) begin
                    o_status.above = 1'b0;
                end
                if (!($signed(r_wnd[4]) < $signed(r_wnd[i]))) begin
                    o_status.below = 1'b0;
                end
            end
        end
    end

endmodule

// File: src/gpvd_result_fifo.sv
// result queue taking up to three results a cycle and giving one a cycle as it is popped
// depends on gpvd_pkg and the assertion macro header
`include "grid_peak_valley_detector_core_macros.svh"

module gpvd_result_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [gpvd_pkg::PUSH_W-1:0]   i_push_cnt,
    input  gpvd_pkg::t_result             i_push_data [gpvd_pkg::MAX_RES],
    input  logic                          i_pop,
    output logic                          o_valid,
    output gpvd_pkg::t_result             o_data,
    output logic [gpvd_pkg::FIFO_CNT_W-1:0] o_count
);
    import gpvd_pkg::*;

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign w_pop   = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (PUSH_W'(k) < i_push_cnt) begin
                r_mem[r_wr_ptr + FIFO_PTR_W'(k)] <= i_push_data[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(i_push_cnt);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_count <= r_count + FIFO_CNT_W'(i_push_cnt) - FIFO_CNT_W'(w_pop);
        end
    end

    `GPVD_ASSERT_IMPL(a_fifo_no_overflow, i_push_cnt != '0,
        (FIFO_CNT_W+1)'(r_count) + (FIFO_CNT_W+1)'(i_push_cnt)
            <= (FIFO_CNT_W+1)'(FIFO_DEPTH) + (FIFO_CNT_W+1)'(w_pop),
        "result queue overflow")

endmodule

// File: src/grid_peak_valley_detector_core.sv
// top level of the grid peak and valley detector
// depends on gpvd_pkg, gpvd_line_ram, gpvd_window, gpvd_result_fifo and the macro header
//
// usage
//   s_axis carries elevation samples of a grid in raster order, one per request.
//   the grid size comes from row_count (index 0) and col_count (index 1) on the
//   plain write port; sizes below 3 act as 3, above 64 act as 64. write only idle.
//   m_axis carries results: interior peaks and valleys (strict against all eight
//   neighbours), then after the last sample the global maximum and minimum with
//   their earliest position; tlast marks the minimum, the final result of a grid.
// throughput
//   one sample per cycle while s_axis_tready is high; the line stores are two 64x16
//   banks, one per row parity, both read and only the parity bank written per sample, so no port is shared.
// pipeline
//   a result shows on m_axis after its sample passes the ram read, the window
//   shift and the window compare into the result queue.
// stall
//   results wait in a 16-entry queue; s_axis_tready drops only when the queue
//   could not hold the worst case of the samples in flight plus one more, and in reset.
// reset
//   synchronous active low; counters, queue and extremes clear, sizes go to 64.
//   line stores need no clearing pass: every read entry that feeds a compare was
//   written earlier in the same grid.
`include "grid_peak_valley_detector_core_macros.svh"

module grid_peak_valley_detector_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [gpvd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gpvd_pkg::DIM_W-1:0]         i_cfg_data,
    // sample input
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [15:0]                        s_axis_tdata,   // [15:0] elevation
    // result output
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [31:0]                        m_axis_tdata,   // [5:0] row_index,
                                                               // [11:6] col_index,
                                                               // [27:12] value, zero pad
    output logic [1:0]                         m_axis_tuser,   // [1:0] kind
    output logic                               m_axis_tlast
);
    import gpvd_pkg::*;

    // configuration registers
    logic [DIM_W-1:0] r_row_count;
    logic [DIM_W-1:0] r_col_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= DIM_W'(MAX_DIM);
            r_col_count <= DIM_W'(MAX_DIM);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                CFG_COL_COUNT: r_col_count <= i_cfg_data;
            endcase
        end
    end

    // raster position of the next sample
    logic [CNT_W-1:0] r_row, n_row;
    logic [CNT_W-1:0] r_col, n_col;

    logic                     w_accept;
    logic signed [ELEV_W-1:0] w_v;
    logic [DIM_W-1:0]         w_rows;
    logic [DIM_W-1:0]         w_cols;
    logic                     w_row_end;
    logic                     w_grid_end;
    logic                     w_first;

    assign w_accept   = s_axis_tvalid & s_axis_tready;
    assign w_v        = signed'(s_axis_tdata[ELEV_W-1:0]);
    assign w_rows     = clamp_dim(r_row_count);
    assign w_cols     = clamp_dim(r_col_count);
    // size may shrink under a running grid, so compare with >=
    assign w_row_end  = (DIM_W'(r_col) + DIM_W'(1)) >= w_cols;
    assign w_grid_end = w_row_end && ((DIM_W'(r_row) + DIM_W'(1)) >= w_rows);
    assign w_first    = (r_row == '0) && (r_col == '0);

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (w_accept) begin
            priority if (w_grid_end) begin
                n_row = '0;
                n_col = '0;
            end else if (w_row_end) begin
                n_row = r_row + CNT_W'(1);
                n_col = '0;
            end else begin
                n_col = r_col + CNT_W'(1);
            end
        end
    end

    // running extremes; strict compares keep the earliest point on ties
    logic signed [ELEV_W-1:0] r_max_val, n_max_val;
    logic [CNT_W-1:0]         r_max_row, n_max_row;
    logic [CNT_W-1:0]         r_max_col, n_max_col;
    logic signed [ELEV_W-1:0] r_min_val, n_min_val;
    logic [CNT_W-1:0]         r_min_row, n_min_row;
    logic [CNT_W-1:0]         r_min_col, n_min_col;

    always_comb begin
        n_max_val = r_max_val;
        n_max_row = r_max_row;
        n_max_col = r_max_col;
        n_min_val = r_min_val;
        n_min_row = r_min_row;
        n_min_col = r_min_col;
        if (w_accept) begin
            if (w_first) begin
                // first sample of a grid seeds both extremes
                n_max_val = w_v;
                n_max_row = '0;
                n_max_col = '0;
                n_min_val = w_v;
                n_min_row = '0;
                n_min_col = '0;
            end else begin
                if (w_v > r_max_val) begin
                    n_max_val = w_v;
                    n_max_row = r_row;
                    n_max_col = r_col;
                end
                if (w_v < r_min_val) begin
                    n_min_val = w_v;
                    n_min_row = r_row;
                    n_min_col = r_col;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_max_val <= '0;
            r_max_row <= '0;
            r_max_col <= '0;
            r_min_val <= '0;
            r_min_row <= '0;
            r_min_col <= '0;
        end else begin
            r_row     <= n_row;
            r_col     <= n_col;
            r_max_val <= n_max_val;
            r_max_row <= n_max_row;
            r_max_col <= n_max_col;
            r_min_val <= n_min_val;
            r_min_row <= n_min_row;
            r_min_col <= n_min_col;
        end
    end

    // line stores: bank of the row parity holds row r-2 and takes the new sample,
    // the other bank holds row r-1; read-first gives the old row r-2 sample
    logic                  w_we_bank0;
    logic                  w_we_bank1;
    logic [ELEV_W-1:0]     w_rd_bank0;
    logic [ELEV_W-1:0]     w_rd_bank1;

    assign w_we_bank0 = w_accept & ~r_row[0];
    assign w_we_bank1 = w_accept &  r_row[0];

    gpvd_line_ram #(
        .DEPTH (MAX_DIM),
        .WIDTH (ELEV_W)
    ) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (w_we_bank0),
        .i_re    (w_accept),
        .i_addr  (r_col),
        .i_wdata (w_v),
        .o_rdata (w_rd_bank0)
    );

    gpvd_line_ram #(
        .DEPTH (MAX_DIM),
        .WIDTH (ELEV_W)
    ) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (w_we_bank1),
        .i_re    (w_accept),
        .i_addr  (r_col),
        .i_wdata (w_v),
        .o_rdata (w_rd_bank1)
    );

    // stage 1: ram data valid, window shifts in the new column
    logic                     r_s1_valid;
    logic                     r_s1_par;
    logic signed [ELEV_W-1:0] r_s1_v;
    logic [CNT_W-1:0]         r_s1_row;
    logic [CNT_W-1:0]         r_s1_col;
    logic                     r_s1_grid_end;
    t_result                  r_s1_max;
    t_result                  r_s1_min;

    // stage 2: window compare, results go to the queue
    logic                     r_s2_valid;
    logic                     r_s2_check;
    logic [CNT_W-1:0]         r_s2_row;
    logic [CNT_W-1:0]         r_s2_col;
    logic                     r_s2_grid_end;
    t_result                  r_s2_max;
    t_result                  r_s2_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    // payload of both stages; extremes are snapshotted with every sample and used at the one that ends a grid
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_par      <= r_row[0];
            r_s1_v        <= w_v;
            r_s1_row      <= r_row;
            r_s1_col      <= r_col;
            r_s1_grid_end <= w_grid_end;
            r_s1_max      <= '{kind: KIND_MAX, row: n_max_row, col: n_max_col,
                               value: n_max_val, last: 1'b0};
            r_s1_min      <= '{kind: KIND_MIN, row: n_min_row, col: n_min_col,
                               value: n_min_val, last: 1'b1};
        end
        if (r_s1_valid) begin
            r_s2_check    <= (r_s1_row >= CNT_W'(2)) && (r_s1_col >= CNT_W'(2));
            r_s2_row      <= r_s1_row - CNT_W'(1);
            r_s2_col      <= r_s1_col - CNT_W'(1);
            r_s2_grid_end <= r_s1_grid_end;
            r_s2_max      <= r_s1_max;
            r_s2_min      <= r_s1_min;
        end
    end

    t_wnd_col    w_col;
    t_wnd_status w_status;

    always_comb begin
        w_col.top = r_s1_par ? w_rd_bank1 : w_rd_bank0;
        w_col.mid = r_s1_par ? w_rd_bank0 : w_rd_bank1;
        w_col.bot = r_s1_v;
    end

    gpvd_window u_window (
        .i_clk    (i_clk),
        .i_shift  (r_s1_valid),
        .i_col    (w_col),
        .o_status (w_status)
    );

    // compose the results of one sample in output order
    logic              w_pv;
    t_result           w_pv_res;
    t_result           w_push_data [MAX_RES];
    logic [PUSH_W-1:0] w_push_cnt;

    assign w_pv = r_s2_valid && r_s2_check && (w_status.above || w_status.below);

    always_comb begin
        w_pv_res.kind  = w_status.above ? KIND_PEAK : KIND_VALLEY;
        w_pv_res.row   = r_s2_row;
        w_pv_res.col   = r_s2_col;
        w_pv_res.value = w_status.center;
        w_pv_res.last  = 1'b0;
    end

    always_comb begin
        w_push_data[0] = r_s2_max;
        w_push_data[1] = r_s2_min;
        w_push_data[2] = r_s2_min;
        w_push_cnt     = '0;
        if (r_s2_valid) begin
            priority if (w_pv && r_s2_grid_end) begin
                w_push_data[0] = w_pv_res;
                w_push_data[1] = r_s2_max;
                w_push_data[2] = r_s2_min;
                w_push_cnt     = PUSH_W'(3);
            end else if (w_pv) begin
                w_push_data[0] = w_pv_res;
                w_push_cnt     = PUSH_W'(1);
            end else if (r_s2_grid_end) begin
                w_push_cnt     = PUSH_W'(2);
            end else begin
                w_push_cnt     = '0;
            end
        end
    end

    t_result               w_out;
    logic [FIFO_CNT_W-1:0] w_fifo_count;

    gpvd_result_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_cnt  (w_push_cnt),
        .i_push_data (w_push_data),
        .i_pop       (m_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_data      (w_out),
        .o_count     (w_fifo_count)
    );

    // room for the worst case of every sample in flight and one more
    logic [FIFO_CNT_W:0] w_reserve;

    assign w_reserve = (FIFO_CNT_W+1)'(w_fifo_count)
                     + (FIFO_CNT_W+1)'(MAX_RES) * (FIFO_CNT_W+1)'(r_s1_valid)
                     + (FIFO_CNT_W+1)'(MAX_RES) * (FIFO_CNT_W+1)'(r_s2_valid);

    assign s_axis_tready = i_rst_n && (w_reserve <= (FIFO_CNT_W+1)'(FIFO_DEPTH - MAX_RES));

    assign m_axis_tdata = {4'b0000, w_out.value, w_out.col, w_out.row};
    assign m_axis_tuser = w_out.kind;
    assign m_axis_tlast = w_out.last;

    `GPVD_ASSERT_IMPL(a_last_only_on_min, m_axis_tvalid && m_axis_tlast,
        m_axis_tuser == KIND_MIN, "tlast on a result other than the global minimum")

    `GPVD_ASSERT_NEXT(a_accept_enters_s1, w_accept, r_s1_valid,
        "accepted sample did not enter the pipeline")

    `GPVD_ASSERT_IMPL(a_grid_end_pushes_extremes, r_s2_valid && r_s2_grid_end,
        w_push_cnt >= PUSH_W'(2), "grid end without both extremes queued")

endmodule
